[rtl/core/atvs_pkg.sv]
`timescale 1ns / 1ps
package atvs_pkg;
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int ADDRESS_BITS      = 48;
   localparam int CSR_ADDR_BITS     = 6;

   // Register byte addresses (8-byte spacing, some registers are 64 bits).
   localparam logic [CSR_ADDR_BITS-1:0] REG_SCAN_TYPE      = 6'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_COMPARE_MODE   = 6'd8;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ALIGNMENT      = 6'd16;
   localparam logic [CSR_ADDR_BITS-1:0] REG_REFERENCE_LOW  = 6'd24;
   localparam logic [CSR_ADDR_BITS-1:0] REG_REFERENCE_HIGH = 6'd32;
   localparam logic [CSR_ADDR_BITS-1:0] REG_STRING_LENGTH  = 6'd40;

   localparam logic [2:0] TYPE_INT8   = 3'd0;
   localparam logic [2:0] TYPE_INT16  = 3'd1;
   localparam logic [2:0] TYPE_INT32  = 3'd2;
   localparam logic [2:0] TYPE_INT64  = 3'd3;
   localparam logic [2:0] TYPE_FLOAT  = 3'd4;
   localparam logic [2:0] TYPE_DOUBLE = 3'd5;
   localparam logic [2:0] TYPE_STRING = 3'd6;

   localparam logic [1:0] MODE_EQUAL   = 2'd0;
   localparam logic [1:0] MODE_LESS    = 2'd1;
   localparam logic [1:0] MODE_GREATER = 2'd2;
   localparam logic [1:0] MODE_UNKNOWN = 2'd3;

   // Byte held in one window cell.
   typedef struct packed {
      logic [7:0] data;
      logic       mark;
   } cell_type;
endpackage

[rtl/core/atvs_stream_if.sv]
`timescale 1ns / 1ps
interface atvs_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/atvs_cell.sv]
`timescale 1ns / 1ps
module atvs_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic                 clear,
   input  atvs_pkg::cell_type   cell_in,
   output atvs_pkg::cell_type   cell_out
);
   atvs_pkg::cell_type cell_ff, cell_in_next;

   // A region start empties the cell before the shift.
   always_comb begin
      cell_in_next = cell_in;
      if (clear) begin
         cell_in_next = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (shift) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;
endmodule

[rtl/core/atvs_compare.sv]
`timescale 1ns / 1ps
module atvs_compare (
   input  logic [2:0]   scan_type,
   input  logic [1:0]   compare_mode,
   input  logic [63:0]  reference_low,
   input  logic [63:0]  value,
   output logic         hit
);
   logic        s_eq, s_lt;
   logic [63:0] a, b;
   logic        f_nan, f_zero, f_eq, f_lt, neg_a, neg_b;
   logic [62:0] ma, mb;

   always_comb begin
      a = value;
      b = reference_low;
      case (scan_type) inside
         atvs_pkg::TYPE_INT8: begin
            a = {{56{value[7]}}, value[7:0]};
            b = {{56{reference_low[7]}}, reference_low[7:0]};
         end
         atvs_pkg::TYPE_INT16: begin
            a = {{48{value[15]}}, value[15:0]};
            b = {{48{reference_low[15]}}, reference_low[15:0]};
         end
         atvs_pkg::TYPE_INT64, atvs_pkg::TYPE_DOUBLE: begin
            a = value;
            b = reference_low;
         end
         default: begin
            a = {{32{value[31]}}, value[31:0]};
            b = {{32{reference_low[31]}}, reference_low[31:0]};
         end
      endcase
      s_eq = (a == b);
      s_lt = ($signed(a) < $signed(b));

      // Sign-magnitude compare for IEEE values.
      if (scan_type == atvs_pkg::TYPE_FLOAT) begin
         neg_a = value[31];
         neg_b = reference_low[31];
         ma = {32'd0, value[30:0]};
         mb = {32'd0, reference_low[30:0]};
         f_nan = (value[30:23] == 8'hFF && value[22:0] != 0) ||
                 (reference_low[30:23] == 8'hFF && reference_low[22:0] != 0);
      end else begin
         neg_a = value[63];
         neg_b = reference_low[63];
         ma = value[62:0];
         mb = reference_low[62:0];
         f_nan = (value[62:52] == 11'h7FF && value[51:0] != 0) ||
                 (reference_low[62:52] == 11'h7FF && reference_low[51:0] != 0);
      end
      f_zero = (ma == 0) && (mb == 0);
      f_eq = !f_nan && (f_zero || (neg_a == neg_b && ma == mb));
      if (f_nan || f_zero) begin
         f_lt = 1'b0;
      end else if (neg_a != neg_b) begin
         f_lt = neg_a;
      end else if (neg_a) begin
         f_lt = ma > mb;
      end else begin
         f_lt = ma < mb;
      end

      hit = 1'b0;
      if (scan_type == atvs_pkg::TYPE_FLOAT || scan_type == atvs_pkg::TYPE_DOUBLE) begin
         case (compare_mode)
            atvs_pkg::MODE_EQUAL:   hit = f_eq;
            atvs_pkg::MODE_LESS:    hit = f_lt;
            atvs_pkg::MODE_GREATER: hit = !f_nan && !f_eq && !f_lt;
            default:                hit = 1'b1;
         endcase
      end else begin
         case (compare_mode)
            atvs_pkg::MODE_EQUAL:   hit = s_eq;
            atvs_pkg::MODE_LESS:    hit = s_lt;
            atvs_pkg::MODE_GREATER: hit = !s_eq && !s_lt;
            default:                hit = 1'b1;
         endcase
      end
   end
endmodule

[rtl/core/aligned_typed_value_scanner_unit.sv]
`timescale 1ns / 1ps
// Aligned typed value scanner.
// The req channel carries one memory byte per transaction with its address
// and a region-start flag; the rsp channel carries match address and value.
// The csr port is APB-style with 64-bit data; registers lie 8 bytes apart
// (scan type, compare_mode, alignment, reference_low, reference_high,
// string_length). Writes take effect on the access cycle; reads return the
// stored values.
// Bytes move through a row of window cells that hold every byte of the
// longest pattern except the newest one; the row shifts on each accepted
// byte. Throughput is one byte per cycle unless a stalled result holds
// the output register. The compare of the window just filled is registered,
// so a match appears on rsp in the cycle after the byte that completes it.
// Reset clears the window, the fill and phase counters and the registers
// to their defaults. When the receiver stalls, the output register holds
// its transaction and req stays ready only while that register can drain
// in the same cycle.
module aligned_typed_value_scanner_unit #(
   parameter int MAX_PATTERN_BYTES = atvs_pkg::MAX_PATTERN_BYTES,
   parameter int ADDRESS_BITS      = atvs_pkg::ADDRESS_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   atvs_stream_if.sink                         req,
   atvs_stream_if.source                       rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [atvs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [63:0]                         csr_pwdata,
   output logic [63:0]                         csr_prdata,
   output logic                                csr_pready
);
   localparam int FILL_BITS = $clog2(MAX_PATTERN_BYTES + 1);

   logic [2:0]  scan_type_ff;
   logic [1:0]  compare_mode_ff;
   logic [3:0]  alignment_ff;
   logic [63:0] reference_low_ff, reference_high_ff;
   logic [4:0]  string_length_ff;

   // Configuration writes.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_type_ff      <= atvs_pkg::TYPE_INT32;
         compare_mode_ff   <= atvs_pkg::MODE_EQUAL;
         alignment_ff      <= 4'd4;
         reference_low_ff  <= '0;
         reference_high_ff <= '0;
         string_length_ff  <= 5'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            atvs_pkg::REG_SCAN_TYPE:      scan_type_ff      <= csr_pwdata[2:0];
            atvs_pkg::REG_COMPARE_MODE:   compare_mode_ff   <= csr_pwdata[1:0];
            atvs_pkg::REG_ALIGNMENT:      alignment_ff      <= csr_pwdata[3:0];
            atvs_pkg::REG_REFERENCE_LOW:  reference_low_ff  <= csr_pwdata;
            atvs_pkg::REG_REFERENCE_HIGH: reference_high_ff <= csr_pwdata;
            atvs_pkg::REG_STRING_LENGTH:  string_length_ff  <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_paddr)
         atvs_pkg::REG_SCAN_TYPE:      csr_prdata = {61'd0, scan_type_ff};
         atvs_pkg::REG_COMPARE_MODE:   csr_prdata = {62'd0, compare_mode_ff};
         atvs_pkg::REG_ALIGNMENT:      csr_prdata = {60'd0, alignment_ff};
         atvs_pkg::REG_REFERENCE_LOW:  csr_prdata = reference_low_ff;
         atvs_pkg::REG_REFERENCE_HIGH: csr_prdata = reference_high_ff;
         atvs_pkg::REG_STRING_LENGTH:  csr_prdata = {59'd0, string_length_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // Input payload unpacking.
   logic [7:0]              in_data;
   logic [ADDRESS_BITS-1:0] in_addr;
   logic                    in_first;
   assign in_data  = req.payload[7:0];
   assign in_addr  = req.payload[ADDRESS_BITS+7:8];
   assign in_first = req.payload[ADDRESS_BITS+8];

   logic rsp_valid_ff;
   logic accept;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Effective alignment and phase counter.
   logic [3:0] step;
   logic [2:0] align_phase_ff, align_phase_in, phase_now;
   logic [FILL_BITS-1:0] fill_ff, fill_in, fill_now;
   always_comb begin
      step = alignment_ff;
      if (alignment_ff == 4'd0) step = 4'd1;
      if (alignment_ff > 4'd8)  step = 4'd8;
      phase_now = in_first ? 3'd0 : align_phase_ff;
      fill_now  = in_first ? '0 : fill_ff;
      align_phase_in = ({1'b0, phase_now} + 4'd1 >= step) ? 3'd0 : phase_now + 3'd1;
      fill_in = (fill_now < FILL_BITS'(MAX_PATTERN_BYTES)) ? fill_now + 1'b1 : fill_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_phase_ff <= '0;
         fill_ff        <= '0;
      end else if (accept) begin
         align_phase_ff <= align_phase_in;
         fill_ff        <= fill_in;
      end
   end

   // Row of window cells; cell 0 takes the new byte.
   atvs_pkg::cell_type cells_in  [MAX_PATTERN_BYTES-1];
   atvs_pkg::cell_type cells_out [MAX_PATTERN_BYTES-1];
   assign cells_in[0] = '{data: in_data, mark: (phase_now == 3'd0)};
   for (genvar g = 0; g < MAX_PATTERN_BYTES - 1; g++) begin : g_cell
      if (g > 0) begin : g_link
         assign cells_in[g] = cells_out[g-1];
      end
      atvs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (accept),
         .clear    (in_first && (g > 0)),
         .cell_in  (cells_in[g]),
         .cell_out (cells_out[g])
      );
   end

   // Candidate window after this byte (index 0 newest).
   logic [7:0] win [MAX_PATTERN_BYTES];
   logic       mk  [MAX_PATTERN_BYTES];
   always_comb begin
      win[0] = in_data;
      mk[0]  = (phase_now == 3'd0);
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         win[i] = in_first ? 8'd0 : cells_out[i-1].data;
         mk[i]  = in_first ? 1'b0 : cells_out[i-1].mark;
      end
   end

   logic [6:0] size;
   always_comb begin
      case (scan_type_ff) inside
         atvs_pkg::TYPE_INT8:   size = 7'd1;
         atvs_pkg::TYPE_INT16:  size = 7'd2;
         atvs_pkg::TYPE_INT64, atvs_pkg::TYPE_DOUBLE: size = 7'd8;
         atvs_pkg::TYPE_STRING: begin
            size = {2'd0, string_length_ff};
            if (string_length_ff == 5'd0) size = 7'd1;
            if (string_length_ff > 5'd16) size = 7'd16;
            if (size > 7'(MAX_PATTERN_BYTES)) size = 7'(MAX_PATTERN_BYTES);
         end
         default: size = 7'd4;
      endcase
   end

   // Little-endian numeric value and string compare.
   logic [63:0] value;
   logic        str_hit, num_hit, start_ok, hit;
   always_comb begin
      value = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < int'(size) && k < MAX_PATTERN_BYTES)
            value[8*k +: 8] = win[int'(size) - 1 - k];
      end
      str_hit = 1'b1;
      for (int k = 0; k < 16; k++) begin
         if (k < int'(size) && k < MAX_PATTERN_BYTES) begin
            if (win[int'(size) - 1 - k] !=
                (k < 8 ? reference_low_ff[8*k +: 8] : reference_high_ff[8*(k-8) +: 8]))
               str_hit = 1'b0;
         end
      end
      start_ok = (7'(fill_in) >= size) && mk[int'(size) - 1];
   end

   atvs_compare u_compare (
      .scan_type     (scan_type_ff),
      .compare_mode  (compare_mode_ff),
      .reference_low (reference_low_ff),
      .value         (value),
      .hit           (num_hit)
   );

   assign hit = start_ok &&
                ((scan_type_ff == atvs_pkg::TYPE_STRING) ? str_hit : num_hit);

   // Output register.
   logic [ADDRESS_BITS-1:0] out_addr_ff;
   logic [63:0]             out_value_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req.ready) begin
         rsp_valid_ff <= accept && hit;
      end
   end
   always_ff @(posedge clock) begin
      if (accept && hit) begin
         out_addr_ff  <= in_addr - ADDRESS_BITS'(size - 7'd1);
         out_value_ff <= (scan_type_ff == atvs_pkg::TYPE_STRING) ? 64'd0 : value;
      end
   end
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = {out_value_ff, out_addr_ff};

   // A stalled result holds its transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("stalled result changed");
   // No input taken while a stalled result cannot drain.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !accept)
      else $error("input accepted during stall");
   // Phase stays below eight, the largest effective step.
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, align_phase_ff} < 4'd8)
      else $error("phase out of range");
endmodule

[sim/tb_stream_if.sv]
`timescale 1ns / 1ps
// The scanner's own stream interface (atvs_stream_if) is taken from the RTL.
// This file holds the bench-side transaction layouts carried by its payload.
package tb_scan_types_pkg;
   // One scanned memory byte, as carried by the req payload.
   typedef struct packed {
      logic        first_of_region;
      logic [47:0] byte_address;
      logic [7:0]  data_byte;
   } scan_byte_type;

   // One match, as carried by the rsp payload.
   typedef struct packed {
      logic [63:0] match_value;
      logic [47:0] match_address;
   } match_type;
endpackage

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
   typedef enum int {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [atvs_pkg::CSR_ADDR_BITS-1:0]  reg_addr;
      logic [63:0]                         reg_data;
      logic [7:0]                          data;
      logic [47:0]                         addr;
      logic                                first;
      bit                                  typed;
      bit                                  hit;
      logic [47:0]                         exp_addr;
      logic [63:0]                         exp_value;
   } stim_row_type;

   typedef struct {
      bit                           typed;
      bit                           hit;
      tb_scan_types_pkg::match_type m;
   } typed_exp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [atvs_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [63:0]                        csr_pwdata = '0;
   logic [63:0]                        csr_prdata;
   logic                               csr_pready;

   atvs_stream_if #(.WIDTH($bits(tb_scan_types_pkg::scan_byte_type))) req_if ();
   atvs_stream_if #(.WIDTH($bits(tb_scan_types_pkg::match_type)))     rsp_if ();

   aligned_typed_value_scanner_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Shadow copy of the registers and the scan window.
   logic [2:0]  cfg_type = atvs_pkg::TYPE_INT32;
   logic [1:0]  cfg_mode = atvs_pkg::MODE_EQUAL;
   logic [3:0]  cfg_align = 4'd4;
   logic [63:0] cfg_ref_low = '0;
   logic [63:0] cfg_ref_high = '0;
   logic [4:0]  cfg_str_len = 5'd1;
   logic [7:0]  win_bytes [16];
   bit          win_marks [16];
   int          region_fill = 0;
   int          align_phase = 0;

   tb_scan_types_pkg::match_type match_q [$];
   typed_exp_type                typed_q [$];
   int                           error_count = 0;
   bit                           quiet = 0;

   function automatic int value_bytes();
      case (cfg_type)
         atvs_pkg::TYPE_INT8:   return 1;
         atvs_pkg::TYPE_INT16:  return 2;
         atvs_pkg::TYPE_INT64:  return 8;
         atvs_pkg::TYPE_FLOAT:  return 4;
         atvs_pkg::TYPE_DOUBLE: return 8;
         atvs_pkg::TYPE_STRING:
            return (cfg_str_len == 0) ? 1 : (cfg_str_len > 16 ? 16 : cfg_str_len);
         default:     return 4;
      endcase
   endfunction

   function automatic int align_step();
      return (cfg_align == 0) ? 1 : (cfg_align > 8 ? 8 : cfg_align);
   endfunction

   // IEEE compare: NaN never matches and both zeros map to the same key.
   function automatic bit float_compare(logic [63:0] a, logic [63:0] b, bit dbl,
                                        logic [1:0] mode);
      bit          nan_a, nan_b;
      logic [63:0] mag_a, mag_b;
      longint      key_a, key_b;
      if (dbl) begin
         nan_a = (a[62:52] == '1) && (a[51:0] != 0);
         nan_b = (b[62:52] == '1) && (b[51:0] != 0);
         mag_a = {1'b0, a[62:0]};
         mag_b = {1'b0, b[62:0]};
         key_a = a[63] ? -longint'(mag_a) : longint'(mag_a);
         key_b = b[63] ? -longint'(mag_b) : longint'(mag_b);
      end else begin
         nan_a = (a[30:23] == '1) && (a[22:0] != 0);
         nan_b = (b[30:23] == '1) && (b[22:0] != 0);
         mag_a = {33'd0, a[30:0]};
         mag_b = {33'd0, b[30:0]};
         key_a = a[31] ? -longint'(mag_a) : longint'(mag_a);
         key_b = b[31] ? -longint'(mag_b) : longint'(mag_b);
      end
      if (nan_a || nan_b) return 0;
      case (mode)
         atvs_pkg::MODE_EQUAL: return key_a == key_b;
         atvs_pkg::MODE_LESS:  return key_a < key_b;
         default:              return key_a > key_b;
      endcase
   endfunction

   function automatic bit value_matches(logic [63:0] v, int n);
      longint sv, sr;
      if (cfg_mode == atvs_pkg::MODE_UNKNOWN) return 1;
      if (cfg_type == atvs_pkg::TYPE_FLOAT) return float_compare(v, cfg_ref_low, 0, cfg_mode);
      if (cfg_type == atvs_pkg::TYPE_DOUBLE) return float_compare(v, cfg_ref_low, 1, cfg_mode);
      sv = longint'(v << (64 - 8 * n)) >>> (64 - 8 * n);
      sr = longint'(cfg_ref_low << (64 - 8 * n)) >>> (64 - 8 * n);
      case (cfg_mode)
         atvs_pkg::MODE_EQUAL: return sv == sr;
         atvs_pkg::MODE_LESS:  return sv < sr;
         default:              return sv > sr;
      endcase
   endfunction

   function automatic logic [7:0] pattern_byte(int k);
      return (k < 8) ? cfg_ref_low[8 * k +: 8] : cfg_ref_high[8 * (k - 8) +: 8];
   endfunction

   // Advances the window by one byte and works out the match it yields, if any.
   function automatic bit scan_step(logic [7:0] d, logic [47:0] a, logic f,
                                    output tb_scan_types_pkg::match_type m);
      int          n;
      int          step;
      bit          ok;
      logic [63:0] v;
      m = '0;
      step = align_step();
      if (f) begin
         foreach (win_bytes[i]) begin
            win_bytes[i] = '0;
            win_marks[i] = 0;
         end
         region_fill = 0;
         align_phase = 0;
      end
      for (int i = 15; i > 0; i--) begin
         win_bytes[i] = win_bytes[i - 1];
         win_marks[i] = win_marks[i - 1];
      end
      win_bytes[0] = d;
      win_marks[0] = (align_phase == 0);
      if (region_fill < 16) region_fill++;
      align_phase = (align_phase + 1 >= step) ? 0 : align_phase + 1;
      n = value_bytes();
      if (region_fill < n || !win_marks[n - 1]) return 0;
      v = '0;
      if (cfg_type == atvs_pkg::TYPE_STRING) begin
         ok = 1;
         for (int k = 0; k < n; k++)
            if (win_bytes[n - 1 - k] != pattern_byte(k)) ok = 0;
      end else begin
         for (int k = 0; k < n; k++) v[8 * k +: 8] = win_bytes[n - 1 - k];
         ok = value_matches(v, n);
      end
      if (!ok) return 0;
      m.match_address = a - 48'(n - 1);
      m.match_value = v;
      return 1;
   endfunction

   // Input side: predict every accepted transaction.
   always @(posedge clock) begin
      tb_scan_types_pkg::scan_byte_type in_b;
      tb_scan_types_pkg::match_type     pm;
      typed_exp_type                    te;
      bit                               hit;
      if (!reset && req_if.valid && req_if.ready) begin
         in_b = req_if.payload;
         te = typed_q.pop_front();
         hit = scan_step(in_b.data_byte, in_b.byte_address, in_b.first_of_region, pm);
         if (te.typed) begin
            if (te.hit) match_q.push_back(te.m);
         end else if (hit) begin
            match_q.push_back(pm);
         end
      end
   end

   // Output side: compare each match against the oldest expectation.
   always @(posedge clock) begin
      tb_scan_types_pkg::match_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (match_q.size() == 0) begin
            $error("unexpected match at address %h value %h", got.match_address,
                   got.match_value);
            error_count++;
         end else begin
            want = match_q.pop_front();
            if (got.match_address !== want.match_address) begin
               $error("match_address: expected %h, actual %h", want.match_address,
                      got.match_address);
               error_count++;
            end
            if (got.match_value !== want.match_value) begin
               $error("match_value: expected %h, actual %h", want.match_value,
                      got.match_value);
               error_count++;
            end
         end
      end
   end

   // Receiver with random stalls.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   task automatic send_byte(logic [7:0] d, logic [47:0] a, logic f, typed_exp_type te);
      tb_scan_types_pkg::scan_byte_type b;
      int                               gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      b.data_byte = d;
      b.byte_address = a;
      b.first_of_region = f;
      typed_q.push_back(te);
      req_if.payload <= b;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Register writes happen only once the block has drained.
   task automatic write_reg(logic [atvs_pkg::CSR_ADDR_BITS-1:0] ra, logic [63:0] rd);
      req_if.valid <= 1'b0;
      while (match_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ra;
      csr_pwdata <= rd;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (ra)
         atvs_pkg::REG_SCAN_TYPE:      cfg_type = rd[2:0];
         atvs_pkg::REG_COMPARE_MODE:   cfg_mode = rd[1:0];
         atvs_pkg::REG_ALIGNMENT:      cfg_align = rd[3:0];
         atvs_pkg::REG_REFERENCE_LOW:  cfg_ref_low = rd;
         atvs_pkg::REG_REFERENCE_HIGH: cfg_ref_high = rd;
         atvs_pkg::REG_STRING_LENGTH:  cfg_str_len = rd[4:0];
         default: ;
      endcase
   endtask

   function automatic stim_row_type byte_row(logic [7:0] d, logic [47:0] a, logic f);
      stim_row_type r;
      r = '{kind: ROW_BYTE, default: '0};
      r.data = d;
      r.addr = a;
      r.first = f;
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic [7:0] d, logic [47:0] a, logic f,
                                              bit hit, logic [47:0] ea, logic [63:0] ev);
      stim_row_type r;
      r = byte_row(d, a, f);
      r.typed = 1;
      r.hit = hit;
      r.exp_addr = ea;
      r.exp_value = ev;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [atvs_pkg::CSR_ADDR_BITS-1:0] ra,
                                            logic [63:0] rd);
      stim_row_type r;
      r = '{kind: ROW_CSR, default: '0};
      r.reg_addr = ra;
      r.reg_data = rd;
      return r;
   endfunction

   function automatic logic [63:0] random_reference();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'h7FFF_FFFF_FFFF_FFFF;
         3: return 64'h8000_0000_0000_0000;
         4: return 64'h0000_0000_7FC0_0000;
         5: return 64'h7FF8_0000_0000_0000;
         6: return {$urandom, $urandom};
         default: return 64'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] random_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // Stimulus.
   initial begin
      stim_row_type  rows [$];
      typed_exp_type te;
      logic [47:0]   addr;
      logic [7:0]    d;
      logic          f;
      int            offset;
      int            n;
      int            k;
      bit            plant;

      req_if.valid = 1'b0;
      req_if.payload = '0;
      foreach (win_bytes[i]) begin
         win_bytes[i] = '0;
         win_marks[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults, bytes that arrive before any region start.
      rows.push_back(byte_row(8'h00, 48'h0, 1'b0));
      rows.push_back(byte_row(8'h00, 48'h1, 1'b0));
      rows.push_back(byte_row(8'h00, 48'h2, 1'b0));
      rows.push_back(typed_row(8'h00, 48'h3, 1'b0, 1, 48'h0, 64'h0));
      // Signed int8 greater than the most negative value, alignment zero acts as one.
      rows.push_back(csr_row(atvs_pkg::REG_SCAN_TYPE, 64'(atvs_pkg::TYPE_INT8)));
      rows.push_back(csr_row(atvs_pkg::REG_COMPARE_MODE, 64'(atvs_pkg::MODE_GREATER)));
      rows.push_back(csr_row(atvs_pkg::REG_ALIGNMENT, 64'd0));
      rows.push_back(csr_row(atvs_pkg::REG_REFERENCE_LOW, 64'h80));
      rows.push_back(typed_row(8'h7F, 48'hFFFF_FFFF_FFFF, 1'b1, 1, 48'hFFFF_FFFF_FFFF,
                               64'h7F));
      rows.push_back(typed_row(8'h80, 48'h0, 1'b0, 0, '0, '0));
      // Float: positive zero equals negative zero; alignment above eight.
      rows.push_back(csr_row(atvs_pkg::REG_SCAN_TYPE, 64'(atvs_pkg::TYPE_FLOAT)));
      rows.push_back(csr_row(atvs_pkg::REG_COMPARE_MODE, 64'(atvs_pkg::MODE_EQUAL)));
      rows.push_back(csr_row(atvs_pkg::REG_ALIGNMENT, 64'd15));
      rows.push_back(csr_row(atvs_pkg::REG_REFERENCE_LOW, 64'h8000_0000));
      rows.push_back(byte_row(8'h00, 48'h10, 1'b1));
      rows.push_back(byte_row(8'h00, 48'h11, 1'b0));
      rows.push_back(byte_row(8'h00, 48'h12, 1'b0));
      rows.push_back(typed_row(8'h00, 48'h13, 1'b0, 1, 48'h10, 64'h0));
      // Float compare against a NaN never matches.
      rows.push_back(csr_row(atvs_pkg::REG_COMPARE_MODE, 64'(atvs_pkg::MODE_LESS)));
      rows.push_back(csr_row(atvs_pkg::REG_REFERENCE_LOW, 64'h7FC0_0000));
      rows.push_back(byte_row(8'h00, 48'h20, 1'b1));
      rows.push_back(byte_row(8'h00, 48'h21, 1'b0));
      rows.push_back(byte_row(8'h80, 48'h22, 1'b0));
      rows.push_back(typed_row(8'hBF, 48'h23, 1'b0, 0, '0, '0));
      // String with length zero acts as one byte; the value reads as zero.
      rows.push_back(csr_row(atvs_pkg::REG_SCAN_TYPE, 64'(atvs_pkg::TYPE_STRING)));
      rows.push_back(csr_row(atvs_pkg::REG_STRING_LENGTH, 64'd0));
      rows.push_back(csr_row(atvs_pkg::REG_REFERENCE_LOW, 64'h41));
      rows.push_back(csr_row(atvs_pkg::REG_REFERENCE_HIGH, '1));
      rows.push_back(typed_row(8'h41, 48'h30, 1'b1, 1, 48'h30, 64'h0));
      rows.push_back(byte_row(8'h42, 48'h31, 1'b0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            write_reg(rows[i].reg_addr, rows[i].reg_data);
         end else begin
            te.typed = rows[i].typed;
            te.hit = rows[i].hit;
            te.m.match_address = rows[i].exp_addr;
            te.m.match_value = rows[i].exp_value;
            send_byte(rows[i].data, rows[i].addr, rows[i].first, te);
         end
      end

      // Random phases: each sets a fresh configuration, then scans regions in
      // which aligned slots often carry the reference pattern.
      te = '{default: '0};
      addr = '0;
      offset = 0;
      for (int ph = 0; ph < 25; ph++) begin
         quiet = ($urandom_range(0, 3) == 0);
         write_reg(atvs_pkg::REG_SCAN_TYPE, 64'($urandom_range(0, 7)));
         write_reg(atvs_pkg::REG_COMPARE_MODE, 64'($urandom_range(0, 3)));
         write_reg(atvs_pkg::REG_ALIGNMENT, ($urandom_range(0, 3) == 0)
                                            ? 64'($urandom_range(0, 15))
                                            : 64'($urandom_range(1, 8)));
         write_reg(atvs_pkg::REG_REFERENCE_LOW, random_reference());
         write_reg(atvs_pkg::REG_REFERENCE_HIGH, random_reference());
         write_reg(atvs_pkg::REG_STRING_LENGTH, ($urandom_range(0, 3) == 0)
                                                ? 64'($urandom_range(0, 31))
                                                : 64'($urandom_range(1, 6)));
         n = value_bytes();
         plant = 0;
         for (int i = 0; i < 70; i++) begin
            f = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
            if (f) begin
               offset = 0;
               if ($urandom_range(0, 3) == 0)
                  addr = 48'hFFFF_FFFF_FFF0 + 48'($urandom_range(0, 15));
               else
                  addr = {16'($urandom), 32'($urandom)};
            end
            k = offset % align_step();
            if (k == 0) plant = $urandom_range(0, 1);
            if (plant && k < n && $urandom_range(0, 15) != 0)
               d = (cfg_type == atvs_pkg::TYPE_STRING) ? pattern_byte(k)
                                                       : cfg_ref_low[8 * (k % 8) +: 8];
            else
               d = random_data();
            send_byte(d, addr, f, te);
            offset++;
            addr++;
         end
      end
      req_if.valid <= 1'b0;

      while (match_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (error_count == 0 && match_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Leftover expectations are checked at the end; this guards against a hang.
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
